### design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ldpr_pkg.sv
// types, constants and fixed-point helpers of the lens distortion remap
package ldpr_pkg;

  localparam int DEF_IMAGE_SIZE = 640;
  localparam int FRAC = 20;
  localparam int DIV_STAGES = 6;
  localparam int DIV_BITS = 4;

  localparam logic signed [39:0] QMAX = 40'sd8388607;
  localparam logic signed [39:0] QMIN = -40'sd8388608;
  localparam logic signed [23:0] QONE = 24'sd1048576;

  // register indexes
  localparam logic [3:0] REG_FOCAL_X  = 4'd0;
  localparam logic [3:0] REG_FOCAL_Y  = 4'd1;
  localparam logic [3:0] REG_CENTER_X = 4'd2;
  localparam logic [3:0] REG_CENTER_Y = 4'd3;
  localparam logic [3:0] REG_K1       = 4'd4;
  localparam logic [3:0] REG_K2       = 4'd5;
  localparam logic [3:0] REG_P1       = 4'd6;
  localparam logic [3:0] REG_P2       = 4'd7;

  localparam logic [11:0] RST_FOCAL  = 12'd640;
  localparam logic [11:0] RST_CENTER = 12'd320;

  typedef struct packed {
    logic [11:0] src_col;
    logic [11:0] src_row;
    logic [23:0] src_color;
  } in_item_t;

  typedef struct packed {
    logic [11:0] dst_col;
    logic [11:0] dst_row;
    logic [23:0] dst_color;
  } out_item_t;

  typedef struct packed {
    logic [11:0] mag;
    logic        neg;
    logic        ovf;
  } div_in_t;

  typedef struct packed {
    logic [23:0] q;
    logic        neg;
    logic        ovf;
  } div_out_t;

  function automatic logic signed [23:0] sat_q(input logic signed [39:0] v);
    logic signed [23:0] r;
    if (v > QMAX) r = QMAX[23:0];
    else if (v < QMIN) r = QMIN[23:0];
    else r = v[23:0];
    return r;
  endfunction

  // q4.20 times q4.20, floor shift
  function automatic logic signed [23:0] mulq(input logic signed [23:0] a,
                                              input logic signed [23:0] b);
    logic signed [47:0] p;
    p = 48'(a) * 48'(b);
    return sat_q(40'(p >>> FRAC));
  endfunction

  // q1.14 times q4.20, floor shift
  function automatic logic signed [23:0] mulc(input logic signed [15:0] c,
                                              input logic signed [23:0] b);
    logic signed [39:0] p;
    p = 40'(c) * 40'(b);
    return sat_q(p >>> 14);
  endfunction

  function automatic logic signed [23:0] add_q(input logic signed [23:0] a,
                                               input logic signed [23:0] b);
    return sat_q(40'(a) + 40'(b));
  endfunction

endpackage

### design/ldpr_div.sv
// pipelined restoring divider for coordinate normalisation
module ldpr_div import ldpr_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] ld,
  input  logic [11:0]           fd,
  input  div_in_t               din,
  output div_out_t              dout
);

  logic [11:0] rem_r [DIV_STAGES];
  logic [23:0] q_r   [DIV_STAGES];
  logic        neg_r [DIV_STAGES];
  logic        ovf_r [DIV_STAGES];
  logic [11:0] rem_nxt [DIV_STAGES];
  logic [23:0] q_nxt   [DIV_STAGES];

  always_comb begin
    logic [12:0] t;
    logic [11:0] rem;
    logic [23:0] q;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        rem = {4'd0, din.mag[11:4]};
        q = '0;
      end else begin
        rem = rem_r[s-1];
        q = q_r[s-1];
      end
      for (int b = 0; b < DIV_BITS; b++) begin
        // numerator bits below the magnitude's low nibble are zero
        if (s == 0) t = {rem, din.mag[DIV_BITS-1-b]};
        else t = {rem, 1'b0};
        q = {q[22:0], 1'b0};
        if (t >= {1'b0, fd}) begin
          t = t - {1'b0, fd};
          q[0] = 1'b1;
        end
        rem = t[11:0];
      end
      rem_nxt[s] = rem;
      q_nxt[s] = q;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (ld[s]) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s] <= q_nxt[s];
      end
    end
    if (ld[0]) begin
      neg_r[0] <= din.neg;
      ovf_r[0] <= din.ovf;
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      if (ld[s]) begin
        neg_r[s] <= neg_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
      end
    end
  end

  assign dout.q = q_r[DIV_STAGES-1];
  assign dout.neg = neg_r[DIV_STAGES-1];
  assign dout.ovf = ovf_r[DIV_STAGES-1];

endmodule

### design/lens_distortion_pixel_remap.sv
// top level of the lens distortion pixel remap pipeline
// usage:
//   input channel carries one source pixel (column, row, color) per item,
//   accepted when in_valid is high and in_stall is low
//   result channel carries the destination column, row and color, taken
//   when out_valid is high and out_stall is low
//   configuration port writes focal lengths, principal point and the
//   q1.14 coefficients by index; cfg_ready is always high, write only
//   while the pipeline is empty
// timing:
//   17 register stages, one item per cycle sustained while out_stall stays
//   low; the divider (six stages of four quotient bits) is the largest
//   single part of the depth
// stall:
//   each stage loads when it is empty or its successor moves, so bubbles
//   close up and the block keeps taking items while a result waits until
//   every stage holds an item
// reset:
//   synchronous active-low reset empties all stages and restores the
//   register defaults
module lens_distortion_pixel_remap import ldpr_pkg::*; #(
  parameter int IMAGE_SIZE = DEF_IMAGE_SIZE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

`include "assert_macros.svh"

  localparam int NST = 11 + DIV_STAGES;
  localparam int SX = 1 + DIV_STAGES;     // signed coordinate stage
  localparam logic signed [37:0] PIX_TOP = 38'(IMAGE_SIZE - 1) <<< FRAC;
  localparam logic [11:0] PIX_MAX = 12'(IMAGE_SIZE - 1);

  // configuration registers
  logic [11:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic signed [15:0] k1_r, k2_r, p1_r, p2_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r <= RST_FOCAL;
      focal_y_r <= RST_FOCAL;
      center_x_r <= RST_CENTER;
      center_y_r <= RST_CENTER;
      k1_r <= '0;
      k2_r <= '0;
      p1_r <= '0;
      p2_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FOCAL_X:  focal_x_r <= cfg_data[11:0];
        REG_FOCAL_Y:  focal_y_r <= cfg_data[11:0];
        REG_CENTER_X: center_x_r <= cfg_data[11:0];
        REG_CENTER_Y: center_y_r <= cfg_data[11:0];
        REG_K1:       k1_r <= cfg_data;
        REG_K2:       k2_r <= cfg_data;
        REG_P1:       p1_r <= cfg_data;
        REG_P2:       p2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero focal length acts as one
  logic [11:0] fdx, fdy;
  assign fdx = (focal_x_r == '0) ? 12'd1 : focal_x_r;
  assign fdy = (focal_y_r == '0) ? 12'd1 : focal_y_r;

  // valid chain with bubble collapse
  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // color travels alongside
  logic [23:0] color_r [NST];
  always_ff @(posedge clk) begin
    if (rdy[0]) color_r[0] <= in_data.src_color;
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) color_r[k] <= color_r[k-1];
    end
  end

  // stage 0: offsets from the principal point, overflow check
  logic signed [12:0] dx, dy;
  div_in_t divx_nxt, divy_nxt, divx_r, divy_r;

  always_comb begin
    dx = $signed({1'b0, in_data.src_col}) - $signed({1'b0, center_x_r});
    dy = $signed({1'b0, in_data.src_row}) - $signed({1'b0, center_y_r});
    divx_nxt.neg = dx[12];
    divy_nxt.neg = dy[12];
    divx_nxt.mag = dx[12] ? 12'(-dx) : dx[11:0];
    divy_nxt.mag = dy[12] ? 12'(-dy) : dy[11:0];
    // quotient reaches 2^23 exactly when |d| >= 8f
    divx_nxt.ovf = {3'd0, divx_nxt.mag} >= {fdx, 3'd0};
    divy_nxt.ovf = {3'd0, divy_nxt.mag} >= {fdy, 3'd0};
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      divx_r <= divx_nxt;
      divy_r <= divy_nxt;
    end
  end

  div_out_t qx, qy;

  ldpr_div u_div_x (
    .clk  (clk),
    .ld   (rdy[DIV_STAGES:1]),
    .fd   (fdx),
    .din  (divx_r),
    .dout (qx)
  );

  ldpr_div u_div_y (
    .clk  (clk),
    .ld   (rdy[DIV_STAGES:1]),
    .fd   (fdy),
    .din  (divy_r),
    .dout (qy)
  );

  // signed normalised coordinate with saturation
  function automatic logic signed [23:0] to_q(input div_out_t d);
    logic signed [23:0] r;
    if (d.ovf) r = d.neg ? QMIN[23:0] : QMAX[23:0];
    else r = d.neg ? -$signed(d.q) : $signed(d.q);
    return r;
  endfunction

  logic signed [23:0] x_r [SX:SX+5];
  logic signed [23:0] y_r [SX:SX+5];

  always_ff @(posedge clk) begin
    if (rdy[SX]) begin
      x_r[SX] <= to_q(qx);
      y_r[SX] <= to_q(qy);
    end
    for (int k = SX + 1; k <= SX + 5; k++) begin
      if (rdy[k]) begin
        x_r[k] <= x_r[k-1];
        y_r[k] <= y_r[k-1];
      end
    end
  end

  // squares and cross term
  logic signed [23:0] xx_r, yy_r, xy_r;
  always_ff @(posedge clk) begin
    if (rdy[SX+1]) begin
      xx_r <= mulq(x_r[SX], x_r[SX]);
      yy_r <= mulq(y_r[SX], y_r[SX]);
      xy_r <= mulq(x_r[SX], y_r[SX]);
    end
  end

  // radius squared and tangential operands
  logic signed [23:0] r2_r, xy2_r, ax_r, ay_r;
  always_ff @(posedge clk) begin
    if (rdy[SX+2]) begin
      r2_r <= add_q(xx_r, yy_r);
      xy2_r <= sat_q(40'(xy_r) <<< 1);
      ax_r <= add_q(add_q(xx_r, yy_r), sat_q(40'(xx_r) <<< 1));
      ay_r <= add_q(add_q(xx_r, yy_r), sat_q(40'(yy_r) <<< 1));
    end
  end

  // coefficient products
  logic signed [23:0] r4_r, k1r2_r, p1xy_r, p2ax_r, p1ay_r, p2xy_r;
  always_ff @(posedge clk) begin
    if (rdy[SX+3]) begin
      r4_r <= mulq(r2_r, r2_r);
      k1r2_r <= mulc(k1_r, r2_r);
      p1xy_r <= mulc(p1_r, xy2_r);
      p2ax_r <= mulc(p2_r, ax_r);
      p1ay_r <= mulc(p1_r, ay_r);
      p2xy_r <= mulc(p2_r, xy2_r);
    end
  end

  logic signed [23:0] k2r4_r, t1_r, tx_r [SX+4:SX+6], ty_r [SX+4:SX+6];
  always_ff @(posedge clk) begin
    if (rdy[SX+4]) begin
      k2r4_r <= mulc(k2_r, r4_r);
      t1_r <= add_q(QONE, k1r2_r);
      tx_r[SX+4] <= add_q(p1xy_r, p2ax_r);
      ty_r[SX+4] <= add_q(p1ay_r, p2xy_r);
    end
    for (int k = SX + 5; k <= SX + 6; k++) begin
      if (rdy[k]) begin
        tx_r[k] <= tx_r[k-1];
        ty_r[k] <= ty_r[k-1];
      end
    end
  end

  logic signed [23:0] rad_r;
  always_ff @(posedge clk) begin
    if (rdy[SX+5]) rad_r <= add_q(t1_r, k2r4_r);
  end

  logic signed [23:0] xr_r, yr_r;
  always_ff @(posedge clk) begin
    if (rdy[SX+6]) begin
      xr_r <= mulq(x_r[SX+5], rad_r);
      yr_r <= mulq(y_r[SX+5], rad_r);
    end
  end

  logic signed [23:0] xd_r, yd_r;
  always_ff @(posedge clk) begin
    if (rdy[SX+7]) begin
      xd_r <= add_q(xr_r, tx_r[SX+6]);
      yd_r <= add_q(yr_r, ty_r[SX+6]);
    end
  end

  // back to pixels in q.20
  logic signed [37:0] px_r, py_r;
  always_ff @(posedge clk) begin
    if (rdy[SX+8]) begin
      px_r <= 38'(xd_r) * $signed({26'd0, focal_x_r})
              + $signed({6'd0, center_x_r, 20'd0});
      py_r <= 38'(yd_r) * $signed({26'd0, focal_y_r})
              + $signed({6'd0, center_y_r, 20'd0});
    end
  end

  function automatic logic [11:0] clamp_pix(input logic signed [37:0] p);
    logic [11:0] r;
    if (p < 0) r = '0;
    else if (p > PIX_TOP) r = PIX_MAX;
    else r = p[31:20];
    return r;
  endfunction

  logic [11:0] dcol_r, drow_r;
  always_ff @(posedge clk) begin
    if (rdy[SX+9]) begin
      dcol_r <= clamp_pix(px_r);
      drow_r <= clamp_pix(py_r);
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_data.dst_col = dcol_r;
  assign out_data.dst_row = drow_r;
  assign out_data.dst_color = color_r[NST-1];

  // checks
  `ASSERT_CLK(a_stall_full, in_stall |-> (&v_r), "input stalled with an empty stage")
  `ASSERT_CLK(a_col_range, out_valid |-> (out_data.dst_col <= PIX_MAX), "column out of range")
  `ASSERT_CLK(a_row_range, out_valid |-> (out_data.dst_row <= PIX_MAX), "row out of range")
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

### tb/sv/tb_lens_distortion_pixel_remap.sv
// self-checking testbench for the lens distortion pixel remap pipeline
`timescale 1ns / 1ps

module tb_lens_distortion_pixel_remap;
  import ldpr_pkg::*;

  localparam int IMAGE_SIZE = 640;
  localparam int DRAIN_CYCLES = 40;     // pipeline is 17 deep, leave margin
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off
  localparam int RAND_PER_SET = 206;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [15:0] cfg_data;

  lens_distortion_pixel_remap #(.IMAGE_SIZE(IMAGE_SIZE)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // local copy of the lens registers
  logic [11:0]        foc_x, foc_y, cen_x, cen_y;
  logic signed [15:0] k1, k2, p1, p2;

  in_item_t  pixels_to_send[$];
  out_item_t expected_pixels[$];

  int send_idle_pct;
  int recv_idle_pct;
  int errors = 0;
  int results_seen = 0;
  int quiet_cycles;
  int hold_left;
  bit hold_done;

  // ---------------------------------------------------------------
  // fixed-point predictor, q4.20 internal values
  // ---------------------------------------------------------------
  function automatic longint q_clip(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // q4.20 product, floor shift then clip
  function automatic longint q_mul(longint a, longint b);
    return q_clip((a * b) >>> 20);
  endfunction

  // q1.14 coefficient times q4.20 value
  function automatic longint coef_mul(logic signed [15:0] c, longint b);
    return q_clip((longint'(c) * b) >>> 14);
  endfunction

  // pixel to normalized coordinate, quotient truncated toward zero
  function automatic longint to_norm(logic [11:0] pix, logic [11:0] c, logic [11:0] f);
    longint d;
    longint fd;
    d = longint'(pix) - longint'(c);
    fd = (f == 0) ? 64'sd1 : longint'(f);  // zero focal length acts as one
    return q_clip((d * 64'sd1048576) / fd);
  endfunction

  // back to pixels with clamp to the image edge
  function automatic logic [11:0] to_pix(longint v, logic [11:0] c, logic [11:0] f);
    longint p;
    longint top;
    p = v * longint'(f) + longint'(c) * 64'sd1048576;
    top = longint'(IMAGE_SIZE - 1) * 64'sd1048576;
    if (p < 0) return 12'd0;
    if (p > top) return 12'(IMAGE_SIZE - 1);
    return 12'(p >>> 20);
  endfunction

  function automatic out_item_t distort_pixel(in_item_t it);
    longint x, y, xx, yy, xy, r2, r4, rad, xy2, tx, ty, xd, yd;
    out_item_t o;
    x = to_norm(it.src_col, cen_x, foc_x);
    y = to_norm(it.src_row, cen_y, foc_y);
    xx = q_mul(x, x);
    yy = q_mul(y, y);
    xy = q_mul(x, y);
    r2 = q_clip(xx + yy);
    r4 = q_mul(r2, r2);
    // radial gain 1 + k1 r^2 + k2 r^4
    rad = q_clip(q_clip(64'sd1048576 + coef_mul(k1, r2)) + coef_mul(k2, r4));
    // tangential shift
    xy2 = q_clip(2 * xy);
    tx = q_clip(coef_mul(p1, xy2) + coef_mul(p2, q_clip(r2 + q_clip(2 * xx))));
    ty = q_clip(coef_mul(p1, q_clip(r2 + q_clip(2 * yy))) + coef_mul(p2, xy2));
    xd = q_clip(q_mul(x, rad) + tx);
    yd = q_clip(q_mul(y, rad) + ty);
    o.dst_col = to_pix(xd, cen_x, foc_x);
    o.dst_row = to_pix(yd, cen_y, foc_y);
    o.dst_color = it.src_color;
    return o;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // source side: predict each accepted item, then offer the next one
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall)
        expected_pixels = {expected_pixels, distort_pixel(in_data)};
      // a stalled item stays put; a new one is picked only after a take
      if (!in_valid || !in_stall) begin
        if (pixels_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pixels_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // result side: compare each taken item, then pick the next stall
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_data));
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.dst_col !== want.dst_col)
            report_mismatch($sformatf("dst_col %0d, want %0d",
                                      out_data.dst_col, want.dst_col));
          if (out_data.dst_row !== want.dst_row)
            report_mismatch($sformatf("dst_row %0d, want %0d",
                                      out_data.dst_row, want.dst_row));
          if (out_data.dst_color !== want.dst_color)
            report_mismatch($sformatf("dst_color %h, want %h",
                                      out_data.dst_color, want.dst_color));
        end
      end
      // one long hold-off so the pipeline fills and backs up the source
      if (!hold_done && results_seen >= 200) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------
  // watchdog: too long with no item moving on either channel
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------
  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FOCAL_X:  foc_x = val[11:0];
      REG_FOCAL_Y:  foc_y = val[11:0];
      REG_CENTER_X: cen_x = val[11:0];
      REG_CENTER_Y: cen_y = val[11:0];
      REG_K1:       k1 = val;
      REG_K2:       k2 = val;
      REG_P1:       p1 = val;
      REG_P2:       p2 = val;
      default: ;  // indexes past the list are ignored
    endcase
  endtask

  task automatic set_lens(logic [11:0] fx, logic [11:0] fy, logic [11:0] cx,
                          logic [11:0] cy, logic [15:0] a, logic [15:0] b,
                          logic [15:0] c, logic [15:0] d);
    write_reg(REG_FOCAL_X, {4'($urandom), fx});
    write_reg(REG_FOCAL_Y, {4'($urandom), fy});
    write_reg(REG_CENTER_X, {4'($urandom), cx});
    write_reg(REG_CENTER_Y, {4'($urandom), cy});
    write_reg(REG_K1, a);
    write_reg(REG_K2, b);
    write_reg(REG_P1, c);
    write_reg(REG_P2, d);
  endtask

  task automatic add_pixel(logic [11:0] col, logic [11:0] row, logic [23:0] color);
    in_item_t it;
    it.src_col = col;
    it.src_row = row;
    it.src_color = color;
    pixels_to_send = {pixels_to_send, it};
  endtask

  // corners, principal point and alternating bit patterns
  task automatic add_directed_pixels();
    add_pixel(12'd0, 12'd0, 24'h000000);
    add_pixel(12'd4095, 12'd4095, 24'hffffff);
    add_pixel(12'd0, 12'd4095, 24'haaaaaa);
    add_pixel(12'd4095, 12'd0, 24'h555555);
    add_pixel(cen_x, cen_y, 24'h123456);
    add_pixel(12'd639, 12'd639, 24'h800001);
    add_pixel(12'd640, 12'd319, 24'h7ffffe);
    add_pixel(12'haaa, 12'h555, 24'hff00ff);
    add_pixel(12'h555, 12'haaa, 24'h00ff00);
    add_pixel(12'd1, 12'd638, 24'h0f0f0f);
    add_pixel(12'd2047, 12'd2048, 24'hf0f0f0);
    add_pixel(12'd100, 12'd500, 24'h000001);
  endtask

  // mostly pixels inside the image, the rest anywhere in range
  task automatic add_random_pixels(int n);
    repeat (n) begin
      if ($urandom_range(3) != 0)
        add_pixel(12'($urandom_range(IMAGE_SIZE - 1)), 12'($urandom_range(IMAGE_SIZE - 1)),
                  24'($urandom));
      else
        add_pixel(12'($urandom), 12'($urandom), 24'($urandom));
    end
  endtask

  // mild coefficients most of the time, full range now and then
  function automatic logic [15:0] rand_coef();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(4000)) - 2000);
  endfunction

  // wait until every expected result is back, then let the pipe settle
  // checked between edges so the source and sink updates have landed
  task automatic drain();
    @(negedge clk);
    while (pixels_to_send.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 31;
    recv_idle_pct = 88;
    foc_x = RST_FOCAL;
    foc_y = RST_FOCAL;
    cen_x = RST_CENTER;
    cen_y = RST_CENTER;
    k1 = 0;
    k2 = 0;
    p1 = 0;
    p2 = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int set = 0; set < 8; set++) begin
      // receiver-heavy idling first, then sender-heavy, then none
      if (set < 3) begin
        send_idle_pct = 31;
        recv_idle_pct = 88;
      end else if (set < 6) begin
        send_idle_pct = 88;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (set)
        0: ;  // register defaults after reset
        // zero focal length and the coefficient extremes
        1: set_lens(12'd0, 12'd1, 12'd0, 12'd4095,
                    16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        2: set_lens(12'd4095, 12'd4095, 12'd4095, 12'd0,
                    16'h8000, 16'h8000, 16'h8000, 16'h8000);
        default: begin
          set_lens(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                   12'($urandom), 12'($urandom),
                   rand_coef(), rand_coef(), rand_coef(), rand_coef());
          // a write past the register list must change nothing
          write_reg(4'($urandom_range(8, 15)), 16'($urandom));
        end
      endcase
      if (set < 2) add_directed_pixels();
      add_random_pixels(RAND_PER_SET);
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
